/* sv/xbs_pkg.sv */
package xbs_pkg;

  // line bytes of the frame
  localparam logic [7:0] SOH_BYTE  = 8'h01;
  localparam logic [7:0] EOT_BYTE  = 8'h04;
  localparam logic [7:0] ACK_BYTE  = 8'h06;
  localparam logic [7:0] STAR_BYTE = 8'h2A;

  // fill count width, covers every supported block size (up to 63)
  localparam int FILL_W = 6;
  // frame position: block size plus four bytes of framing
  localparam int POS_W  = FILL_W + 1;

  localparam logic [7:0] MAX_TRIES_RST = 8'd10;

  // register byte offsets
  localparam logic [2:0] ADDR_MAX_TRIES = 3'd0;

  // request codes on the input word
  typedef enum logic [1:0] {
    REQ_DATA = 2'd0,
    REQ_EOI  = 2'd1,
    REQ_RESP = 2'd2
  } req_e;

  // status codes on the result word
  typedef enum logic [2:0] {
    STAT_NONE       = 3'd0,
    STAT_ACKED      = 3'd1,
    STAT_FAILED     = 3'd2,
    STAT_COMPLETE   = 3'd3,
    STAT_EOT_NO_ACK = 3'd4
  } status_e;

  // work handed from front to back
  typedef enum logic [1:0] {
    CMD_FRAME  = 2'd0,
    CMD_EOT    = 2'd1,
    CMD_STATUS = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       last_in_block;
    logic       resp_received;
    logic [7:0] resp_byte;
  } in_t;

  typedef struct packed {
    logic       is_tx;
    logic [7:0] tx_byte;
    logic [2:0] status;
    logic [7:0] block_number;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    cmd_kind_e          kind;
    status_e            status;
    logic [7:0]         seq;
    logic [7:0]         chk;
    logic [FILL_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [FILL_W-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

endpackage

/* sv/xbs_front.sv */
module xbs_front #(
  parameter int BLOCK_SIZE = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  xbs_pkg::in_t        in_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  input  logic                q_full,
  input  logic                back_idle,
  output logic                q_push,
  output xbs_pkg::cmd_t       q_cmd,
  output xbs_pkg::buf_wr_t    buf_wr
);
  import xbs_pkg::*;

  typedef enum logic [2:0] {
    PH_FILL,
    PH_WAIT_BLK,
    PH_FAILED,
    PH_WAIT_EOT,
    PH_DONE
  } phase_t;

  localparam logic [FILL_W-1:0] BLK_FULL = FILL_W'(BLOCK_SIZE);

  phase_t            phase_r, phase_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        seq_r, seq_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        tries_r, tries_nxt;
  logic [7:0]        max_tries_r;
  logic              accept;
  logic              acked;
  logic              out_of_tries;
  logic              reg_sel;

  // data words touch the buffer, so they wait until the back has drained
  assign in_ready     = !q_full && (in_data.req_type != REQ_DATA || back_idle);
  assign accept       = in_valid && in_ready;
  assign acked        = in_data.resp_received && (in_data.resp_byte == ACK_BYTE);
  assign out_of_tries = tries_r >= max_tries_r;
  assign reg_sel      = !paddr[2];

  // classify the word and decide the command
  always_comb begin
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    seq_nxt   = seq_r;
    sum_nxt   = sum_r;
    tries_nxt = tries_r;
    q_push    = 1'b0;
    q_cmd     = '{kind: CMD_FRAME, status: STAT_NONE, seq: seq_r,
                  chk: 8'(seq_r + 8'd1 + sum_r), count: fill_r};
    buf_wr    = '{en: 1'b0, addr: fill_r, data: in_data.data_byte};
    if (accept) begin
      case (in_data.req_type)
        REQ_DATA: begin
          if (phase_r == PH_FILL) begin
            if (fill_r < BLK_FULL) begin
              buf_wr.en = 1'b1;
              fill_nxt  = fill_r + 1'b1;
              sum_nxt   = 8'(sum_r + in_data.data_byte);
            end
            if (in_data.last_in_block || fill_nxt >= BLK_FULL) begin
              q_push      = 1'b1;
              q_cmd.chk   = 8'(seq_r + 8'd1 + sum_nxt);
              q_cmd.count = fill_nxt;
              tries_nxt   = 8'd1;
              phase_nxt   = PH_WAIT_BLK;
            end
          end
        end
        REQ_EOI: begin
          if (phase_r == PH_FILL) begin
            q_push    = 1'b1;
            tries_nxt = 8'd1;
            if (fill_r != '0) begin
              phase_nxt = PH_WAIT_BLK;
            end else begin
              q_cmd.kind = CMD_EOT;
              phase_nxt  = PH_WAIT_EOT;
            end
          end
        end
        REQ_RESP: begin
          if (phase_r == PH_WAIT_BLK) begin
            q_push = 1'b1;
            if (acked) begin
              q_cmd.kind   = CMD_STATUS;
              q_cmd.status = STAT_ACKED;
              seq_nxt      = seq_r + 8'd1;
              fill_nxt     = '0;
              sum_nxt      = '0;
              tries_nxt    = '0;
              phase_nxt    = PH_FILL;
            end else if (out_of_tries) begin
              q_cmd.kind   = CMD_STATUS;
              q_cmd.status = STAT_FAILED;
              phase_nxt    = PH_FAILED;
            end else begin
              tries_nxt = tries_r + 8'd1;
            end
          end else if (phase_r == PH_WAIT_EOT) begin
            q_push = 1'b1;
            if (acked) begin
              q_cmd.kind   = CMD_STATUS;
              q_cmd.status = STAT_COMPLETE;
              phase_nxt    = PH_DONE;
            end else if (out_of_tries) begin
              q_cmd.kind   = CMD_STATUS;
              q_cmd.status = STAT_EOT_NO_ACK;
              phase_nxt    = PH_DONE;
            end else begin
              q_cmd.kind = CMD_EOT;
              tries_nxt  = tries_r + 8'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // protocol state and the tries register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FILL;
      fill_r      <= '0;
      seq_r       <= '0;
      sum_r       <= '0;
      tries_r     <= '0;
      max_tries_r <= MAX_TRIES_RST;
    end else begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      seq_r   <= seq_nxt;
      sum_r   <= sum_nxt;
      tries_r <= tries_nxt;
      if (psel && penable && pwrite && reg_sel) begin
        max_tries_r <= pwdata[7:0];
      end
    end
  end

  // register readback
  assign prdata = reg_sel ? {24'd0, max_tries_r} : 32'd0;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= BLK_FULL)
    else $error("fill count beyond block size");

  a_tries_set: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WAIT_BLK || phase_r == PH_WAIT_EOT) |-> tries_r != 8'd0)
    else $error("waiting for a response with no send counted");

  a_buf_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    buf_wr.en |-> back_idle)
    else $error("buffer written while a frame may be read");

endmodule

/* sv/xbs_cmd_queue.sv */
module xbs_cmd_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  xbs_pkg::cmd_t push_cmd,
  input  logic          pop,
  output xbs_pkg::cmd_t head_cmd,
  output logic          empty,
  output logic          full
);
  import xbs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign empty    = count_r == '0;
  assign full     = count_r == CNT_FULL;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = slot_r[rd_ptr_r];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("command pushed into a full queue");

endmodule

/* sv/xbs_back.sv */
module xbs_back #(
  parameter int BLOCK_SIZE = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  xbs_pkg::buf_wr_t buf_wr,
  input  logic             q_empty,
  input  xbs_pkg::cmd_t    q_cmd,
  output logic             q_pop,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_ready,
  output xbs_pkg::out_t    out_data
);
  import xbs_pkg::*;

  localparam int IDX_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t           state_r;
  cmd_t             cmd_r;
  logic [POS_W-1:0] pos_r;
  logic [IDX_W-1:0] didx_r;
  logic [IDX_W-1:0] raddr;
  logic [7:0]       rdata_r;
  logic [7:0]       buf_mem [BLOCK_SIZE];
  logic             out_valid_r;
  out_t             out_r;
  logic             load;
  logic             advance;
  logic [POS_W-1:0] cnt_ext;
  logic [POS_W-1:0] last_pos;
  logic             is_last;
  out_t             word;

  assign cnt_ext  = {1'b0, cmd_r.count};
  assign last_pos = (cmd_r.kind == CMD_FRAME) ? cnt_ext + POS_W'(3) : '0;
  assign is_last  = pos_r == last_pos;
  assign load     = !out_valid_r || out_ready;
  assign advance  = (state_r == ST_EMIT) && load;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign busy     = state_r != ST_IDLE;

  // read address runs one step ahead of the data byte in the frame
  always_comb begin
    if (state_r == ST_IDLE) begin
      raddr = '0;
    end else if (advance && pos_r >= POS_W'(2) && pos_r < cnt_ext + POS_W'(1)) begin
      raddr = IDX_W'(didx_r + 1'b1);
    end else begin
      raddr = didx_r;
    end
  end

  // frame buffer
  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      buf_mem[buf_wr.addr[IDX_W-1:0]] <= buf_wr.data;
    end
    rdata_r <= buf_mem[raddr];
    didx_r  <= raddr;
  end

  // word for the current position of the command
  always_comb begin
    word = '{is_tx: 1'b1, tx_byte: 8'd0, status: STAT_NONE,
             block_number: cmd_r.seq, last_of_run: is_last};
    case (cmd_r.kind)
      CMD_FRAME: begin
        if (pos_r == '0) begin
          word.tx_byte = SOH_BYTE;
        end else if (pos_r == POS_W'(1)) begin
          word.tx_byte = cmd_r.seq;
        end else if (pos_r <= cnt_ext + POS_W'(1)) begin
          word.tx_byte = rdata_r;
        end else if (pos_r == cnt_ext + POS_W'(2)) begin
          word.tx_byte = STAR_BYTE;
        end else begin
          word.tx_byte = cmd_r.chk;
        end
      end
      CMD_EOT: begin
        word.tx_byte = EOT_BYTE;
      end
      CMD_STATUS: begin
        word.is_tx  = 1'b0;
        word.status = cmd_r.status;
      end
      default: begin
        word.is_tx = 1'b0;
      end
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // output word held until taken
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            cmd_r   <= q_cmd;
            pos_r   <= '0;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            out_r <= word;
            pos_r <= pos_r + 1'b1;
            if (is_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> pos_r <= last_pos)
    else $error("frame position past the last byte");

  a_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_last) |=> (out_valid && out_data.last_of_run && state_r == ST_IDLE))
    else $error("command end not marked on its final word");

endmodule

/* sv/xmodem_block_sender.sv */
// flow: a word that starts a frame, EOT or status is pushed into the command
//   queue, then taken by the sequencer and registered at the output; a frame
//   streams one byte a cycle while out_ready holds; data words stall until the
//   command queue and the sequencer are both idle
// reset: rst_n is synchronous and active low; it clears the protocol state,
//   the command queue and the output; the frame buffer is not cleared
module xmodem_block_sender #(
  parameter int BLOCK_SIZE  = 32,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  xbs_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output xbs_pkg::out_t  out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import xbs_pkg::*;

  cmd_t    push_cmd;
  cmd_t    head_cmd;
  buf_wr_t buf_wr;
  logic    q_push;
  logic    q_pop;
  logic    q_empty;
  logic    q_full;
  logic    back_busy;
  logic    back_idle;

  assign pready    = 1'b1;
  assign back_idle = q_empty && !back_busy;

  // accept and classify words, keep the protocol state
  xbs_front #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .q_full    (q_full),
    .back_idle (back_idle),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .buf_wr    (buf_wr)
  );

  // decouple front and back
  xbs_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  // emit frames, EOT and status words
  xbs_back #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .buf_wr    (buf_wr),
    .q_empty   (q_empty),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
